// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL. All of them sample on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BDEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define BDEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/bdeq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bdeq_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 15;
  localparam int CMD_W       = 3;
  localparam int CAP_W       = 11;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int LIM_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int OUT_W       = VALUE_WIDTH + 1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1024);
  localparam logic [OUT_W-1:0] EMPTY_MARK     = '1;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_APPEND,
    CELL_TRUNCATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [VALUE_WIDTH-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic                   valid;
    logic [VALUE_WIDTH-1:0] value;
  } cell_t;

endpackage
`default_nettype wire

// ===== hdl/bdeq_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bdeq_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [bdeq_pkg::CMD_W-1:0]       command;
  logic [bdeq_pkg::VALUE_WIDTH-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/bdeq_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bdeq_res_if;
  logic                              valid;
  logic                              ready;
  logic                              success;
  logic signed [bdeq_pkg::OUT_W-1:0] front_value;
  logic signed [bdeq_pkg::OUT_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;
  logic [bdeq_pkg::CAP_W-1:0]        entry_count;

  modport source (output valid, output success, output front_value, output rear_value,
                  output is_empty, output is_full, output entry_count, input ready);
  modport sink (input valid, input success, input front_value, input rear_value,
                input is_empty, input is_full, input entry_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/bdeq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bdeq_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  bdeq_pkg::cell_ctrl_t      ctrl_i,
  input  bdeq_pkg::cell_t           lower_i,
  input  bdeq_pkg::cell_t           upper_i,
  output bdeq_pkg::cell_t           cell_o
);

  logic                             valid_q, valid_d;
  logic [bdeq_pkg::VALUE_WIDTH-1:0] value_q, value_d;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    unique case (ctrl_i.op)
      bdeq_pkg::CELL_HOLD: begin
      end
      bdeq_pkg::CELL_SHIFT_UP: begin
        valid_d = lower_i.valid;
        value_d = lower_i.value;
      end
      bdeq_pkg::CELL_SHIFT_DOWN: begin
        valid_d = upper_i.valid;
        value_d = upper_i.value;
      end
      bdeq_pkg::CELL_APPEND: begin
        if (!valid_q && lower_i.valid) begin
          valid_d = 1'b1;
          value_d = ctrl_i.value;
        end
      end
      bdeq_pkg::CELL_TRUNCATE: begin
        if (valid_q && !upper_i.valid) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.value = value_q;

endmodule
`default_nettype wire

// ===== hdl/bdeq_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bdeq_chain (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  bdeq_pkg::cell_ctrl_t ctrl_i,
  output bdeq_pkg::cell_t      head_o
);

  bdeq_pkg::cell_t links [bdeq_pkg::DEPTH];
  bdeq_pkg::cell_t entry_word;
  bdeq_pkg::cell_t end_word;

  // The word entering at the head is always valid and carries the pushed value.
  assign entry_word.valid = 1'b1;
  assign entry_word.value = ctrl_i.value;
  assign end_word.valid   = 1'b0;
  assign end_word.value   = '0;

  for (genvar i = 0; i < bdeq_pkg::DEPTH; i++) begin : g_cell
    bdeq_pkg::cell_t lower, upper;

    if (i == 0) begin : g_first
      assign lower = entry_word;
    end else begin : g_inner_lo
      assign lower = links[i-1];
    end

    if (i == bdeq_pkg::DEPTH - 1) begin : g_last
      assign upper = end_word;
    end else begin : g_inner_hi
      assign upper = links[i+1];
    end

    bdeq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .lower_i (lower),
      .upper_i (upper),
      .cell_o  (links[i])
    );
  end

  assign head_o = links[0];

endmodule
`default_nettype wire

// ===== hdl/bounded_double_ended_queue.sv =====
// The result of a command is shown in the cycle after the command word is accepted.
// Throughput: one command per cycle; while a result waits, commands enter only as it is taken.
// Storage is two chains of cells, one read at the front and one read at the rear.
// Reset empties the deque and sets the capacity to 1024; stored values are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bounded_double_ended_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       capacity_we_i,
  input  wire logic [bdeq_pkg::CAP_W-1:0] capacity_i,
  bdeq_cmd_if.sink                        cmd_i,
  bdeq_res_if.source                      res_o
);

  logic [bdeq_pkg::CAP_W-1:0] capacity_q;
  logic [bdeq_pkg::CNT_W-1:0] count_q, count_d;
  logic                       ok_q, ok_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;
  logic                       full, empty;
  logic                       push_ok;
  logic [bdeq_pkg::LIM_W-1:0] limit;
  bdeq_pkg::cell_op_e         front_op, rear_op;
  bdeq_pkg::cell_ctrl_t       front_ctrl, rear_ctrl;
  bdeq_pkg::cell_t            front_head, rear_head;

  always_comb begin
    if (bdeq_pkg::LIM_W'(capacity_q) > bdeq_pkg::LIM_W'(bdeq_pkg::DEPTH)) begin
      limit = bdeq_pkg::LIM_W'(bdeq_pkg::DEPTH);
    end else begin
      limit = bdeq_pkg::LIM_W'(capacity_q);
    end
  end

  assign full   = bdeq_pkg::LIM_W'(count_q) >= limit;
  assign empty  = (count_q == '0);
  assign accept = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = !out_valid_q || res_o.ready;

  always_comb begin
    ok_d     = 1'b0;
    push_ok  = 1'b0;
    front_op = bdeq_pkg::CELL_HOLD;
    rear_op  = bdeq_pkg::CELL_HOLD;
    count_d  = count_q;
    unique case (cmd_i.command)
      bdeq_pkg::CMD_PUSH_FRONT: begin
        if (!full) begin
          ok_d     = 1'b1;
          push_ok  = 1'b1;
          front_op = bdeq_pkg::CELL_SHIFT_UP;
          rear_op  = bdeq_pkg::CELL_APPEND;
          count_d  = count_q + bdeq_pkg::CNT_W'(1);
        end
      end
      bdeq_pkg::CMD_PUSH_REAR: begin
        if (!full) begin
          ok_d     = 1'b1;
          push_ok  = 1'b1;
          front_op = bdeq_pkg::CELL_APPEND;
          rear_op  = bdeq_pkg::CELL_SHIFT_UP;
          count_d  = count_q + bdeq_pkg::CNT_W'(1);
        end
      end
      bdeq_pkg::CMD_POP_FRONT: begin
        if (!empty) begin
          ok_d     = 1'b1;
          front_op = bdeq_pkg::CELL_SHIFT_DOWN;
          rear_op  = bdeq_pkg::CELL_TRUNCATE;
          count_d  = count_q - bdeq_pkg::CNT_W'(1);
        end
      end
      bdeq_pkg::CMD_POP_REAR: begin
        if (!empty) begin
          ok_d     = 1'b1;
          front_op = bdeq_pkg::CELL_TRUNCATE;
          rear_op  = bdeq_pkg::CELL_SHIFT_DOWN;
          count_d  = count_q - bdeq_pkg::CNT_W'(1);
        end
      end
      bdeq_pkg::CMD_STATUS: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign front_ctrl.op    = accept ? front_op : bdeq_pkg::CELL_HOLD;
  assign front_ctrl.value = cmd_i.push_value;
  assign rear_ctrl.op     = accept ? rear_op : bdeq_pkg::CELL_HOLD;
  assign rear_ctrl.value  = cmd_i.push_value;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= bdeq_pkg::CAPACITY_RESET;
      count_q     <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (capacity_we_i) begin
        capacity_q <= capacity_i;
      end
      if (accept) begin
        count_q <= count_d;
        ok_q    <= ok_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  bdeq_chain u_front_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (front_ctrl),
    .head_o (front_head)
  );

  bdeq_chain u_rear_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rear_ctrl),
    .head_o (rear_head)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.success     = ok_q;
  assign res_o.front_value = empty ? bdeq_pkg::EMPTY_MARK : {1'b0, front_head.value};
  assign res_o.rear_value  = empty ? bdeq_pkg::EMPTY_MARK : {1'b0, rear_head.value};
  assign res_o.is_empty    = empty;
  assign res_o.is_full     = full;
  assign res_o.entry_count = bdeq_pkg::CAP_W'(count_q);

  `BDEQ_ASSERT_ALWAYS(a_count_bound, count_q <= bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH), "count exceeds depth")
  `BDEQ_ASSERT(a_front_head, empty == !front_head.valid, "front chain head disagrees with count")
  `BDEQ_ASSERT(a_heads_agree, front_head.valid == rear_head.valid, "front and rear chains disagree")
  `BDEQ_ASSERT(a_push_count, accept && push_ok |=> count_q == $past(count_q) + bdeq_pkg::CNT_W'(1), "push did not raise count")

endmodule
`default_nettype wire

// ===== verif/bounded_double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
module bounded_double_ended_queue_tb;
  import bdeq_pkg::*;

  localparam int          CLK_PERIOD    = 4;
  localparam int          PTR_W         = $clog2(DEPTH);
  localparam int unsigned LIMIT_CYCLES  = 200_000;
  localparam int          CMD_UNUSED_LO = CMD_STATUS + 1;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct {
    logic                    success;
    logic signed [OUT_W-1:0] front_value;
    logic signed [OUT_W-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
    logic [CAP_W-1:0]        entry_count;
  } deque_status_t;

  class deque_tracker;
    logic [VALUE_WIDTH-1:0] entries [DEPTH];
    bit [PTR_W-1:0]         head;
    bit [PTR_W-1:0]         tail;
    bit [CNT_W-1:0]         held;
    bit [CAP_W-1:0]         capacity;
    deque_status_t          awaited_status[$];
    int unsigned            errors;

    function new();
      foreach (entries[i]) entries[i] = '0;
      head     = '0;
      tail     = '0;
      held     = '0;
      capacity = CAPACITY_RESET;
      errors   = 0;
    endfunction

    function bit [PTR_W-1:0] step_up(bit [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function bit [PTR_W-1:0] step_down(bit [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

    function int unsigned room_limit();
      return (32'(capacity) > DEPTH) ? DEPTH : 32'(capacity);
    endfunction

    function void set_capacity(bit [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return awaited_status.size();
    endfunction

    function void apply_command(logic [CMD_W-1:0] cmd, logic [VALUE_WIDTH-1:0] value);
      deque_status_t want;
      bit            was_full;
      bit            was_empty;
      bit            ok;
      was_full  = 32'(held) >= room_limit();
      was_empty = held == '0;
      ok        = 1'b0;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (!was_full) begin
            head          = step_down(head);
            entries[head] = value;
            held++;
            ok = 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          if (!was_full) begin
            entries[tail] = value;
            tail          = step_up(tail);
            held++;
            ok = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (!was_empty) begin
            head = step_up(head);
            held--;
            ok = 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (!was_empty) begin
            tail = step_down(tail);
            held--;
            ok = 1'b1;
          end
        end
        CMD_STATUS: ok = 1'b1;
        default:    ok = 1'b0;
      endcase
      want.success     = ok;
      want.is_empty    = held == '0;
      want.is_full     = 32'(held) >= room_limit();
      want.entry_count = CAP_W'(held);
      if (held == '0) begin
        want.front_value = EMPTY_MARK;
        want.rear_value  = EMPTY_MARK;
      end else begin
        want.front_value = {1'b0, entries[head]};
        want.rear_value  = {1'b0, entries[step_down(tail)]};
      end
      awaited_status.push_back(want);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s: got %0h, expected %0h", field, got, want));
      end
    endtask

    task check_result(deque_status_t got);
      deque_status_t want;
      if (awaited_status.size() == 0) begin
        report("result word with no command outstanding");
      end else begin
        want = awaited_status.pop_front();
        check_field("success", 32'(got.success), 32'(want.success));
        check_field("front_value", 32'(got.front_value), 32'(want.front_value));
        check_field("rear_value", 32'(got.rear_value), 32'(want.rear_value));
        check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        check_field("is_full", 32'(got.is_full), 32'(want.is_full));
        check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      end
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             capacity_we_i;
  logic [CAP_W-1:0] capacity_i;

  bdeq_cmd_if cmd_if ();
  bdeq_res_if res_if ();

  deque_tracker  shadow = new();
  deque_status_t observed;
  int unsigned   burst_left;
  int unsigned   cycle_count;
  bit            random_started;
  bit            long_hold_done;

  bounded_double_ended_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capacity_we_i (capacity_we_i),
    .capacity_i    (capacity_i),
    .cmd_i         (cmd_if),
    .res_o         (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        shadow.apply_command(cmd_if.command, cmd_if.push_value);
      end
      if (res_if.valid && res_if.ready) begin
        observed.success     = res_if.success;
        observed.front_value = res_if.front_value;
        observed.rear_value  = res_if.rear_value;
        observed.is_empty    = res_if.is_empty;
        observed.is_full     = res_if.is_full;
        observed.entry_count = res_if.entry_count;
        shadow.check_result(observed);
      end
    end
  end

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned rx_tick;
    res_if.ready <= 1'b0;
    mode      = RX_STEADY;
    mode_left = 0;
    hold_left = 0;
    rx_tick   = 0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      rx_tick++;
      // A long hold-off lets the deque back up until it refuses command words.
      if (hold_left == 0 && random_started && !long_hold_done) begin
        hold_left      = 120;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && $urandom_range(0, 499) == 0) begin
        hold_left = $urandom_range(20, 60);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(RX_STEADY, RX_PERIODIC));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY:   res_if.ready <= 1'b1;
          RX_COIN:     res_if.ready <= 1'($urandom_range(0, 1));
          default:     res_if.ready <= (rx_tick % 4) != 3;
        endcase
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_WIDTH-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.push_value <= value;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    capacity_we_i <= 1'b1;
    capacity_i    <= value;
    @(posedge clk_i);
    capacity_we_i <= 1'b0;
    shadow.set_capacity(value);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned push_w,
                            input int unsigned pop_w, input int unsigned status_w);
    int unsigned            pick;
    logic [CMD_W-1:0]       cmd;
    logic [VALUE_WIDTH-1:0] value;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < push_w) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      end else if (pick < push_w + pop_w) begin
        cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
      end else if (pick < push_w + pop_w + status_w) begin
        cmd = CMD_STATUS;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, (1 << CMD_W) - 1));
      end
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = '1;
        default: value = VALUE_WIDTH'($urandom());
      endcase
      send_word(cmd, value);
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    capacity_we_i     <= 1'b0;
    capacity_i        <= CAPACITY_RESET;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= CMD_STATUS;
    cmd_if.push_value <= '0;
    cycle_count        = 0;
    burst_left         = 0;
    random_started     = 1'b0;
    long_hold_done     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_STATUS, '0);
    send_word(CMD_POP_FRONT, '1);
    send_word(CMD_POP_REAR, '0);
    send_word(CMD_PUSH_REAR, '1);
    send_word(CMD_PUSH_FRONT, '0);
    send_word(CMD_STATUS, '1);
    send_word(CMD_PUSH_REAR, 15'h5555);
    send_word(CMD_PUSH_FRONT, 15'h2AAA);
    for (int c = CMD_UNUSED_LO; c < (1 << CMD_W); c++) begin
      send_word(CMD_W'(c), VALUE_WIDTH'($urandom()));
    end
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_REAR, '0);
    send_word(CMD_POP_REAR, '1);
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_FRONT, '0);

    set_capacity('0);
    send_word(CMD_PUSH_FRONT, 15'h1234);
    send_word(CMD_PUSH_REAR, '1);
    set_capacity(CAP_W'(1));
    send_word(CMD_PUSH_REAR, '1);
    send_word(CMD_PUSH_FRONT, 15'h0001);
    send_word(CMD_POP_REAR, '0);

    set_capacity(CAP_W'(16));
    random_started = 1'b1;
    run_random(50, 70, 20, 5);
    set_capacity(CAP_W'(3));
    run_random(40, 30, 55, 10);
    set_capacity(CAP_W'(1));
    run_random(40, 50, 40, 5);
    set_capacity('0);
    run_random(20, 60, 25, 10);
    set_capacity(CAP_W'(2));
    run_random(40, 50, 40, 5);
    set_capacity(CAP_W'($urandom_range(1, 40)));
    run_random(60, 55, 35, 5);
    set_capacity('1);
    run_random(1060, 99, 0, 1);
    set_capacity(CAP_W'(DEPTH + 1));
    run_random(30, 50, 40, 5);
    set_capacity(CAPACITY_RESET);
    run_random(40, 30, 60, 5);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
